[rtl/weighted_priority_tick_scheduler_assert.svh]
// assertion macros for the tick scheduler checker
`ifndef WEIGHTED_PRIORITY_TICK_SCHEDULER_ASSERT_SVH
`define WEIGHTED_PRIORITY_TICK_SCHEDULER_ASSERT_SVH
// implication checked every clock outside reset
`define WPTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define WPTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/wpts_pkg.sv]
// ----------------------------------------------------------------------------
// wpts_pkg
// types and constants shared by the tick scheduler modules
// ----------------------------------------------------------------------------
package wpts_pkg;
  localparam int QueueDepth = 1024;
  localparam int AddrW = $clog2(QueueDepth);
  localparam int CountW = AddrW + 1;
  localparam int PenW = 48;
  localparam logic [PenW-1:0] PenMax = {PenW{1'b1}};

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_ZERO = 2'd2;

  typedef struct packed {
    logic [15:0] weight;
    logic [15:0] work;
  } entry_t;

  typedef struct packed {
    logic        command;
    logic [15:0] priority_req;
    logic [15:0] work;
  } req_t;

  typedef struct packed {
    logic        served;
    logic [15:0] served_priority;
    logic [47:0] penalty;
    logic [1:0]  error;
    logic [10:0] occupancy;
  } rsp_t;

  // memory port bundle between sequencer and heap memory
  typedef struct packed {
    logic        re;
    logic [AddrW-1:0] raddr;
    logic        we;
    logic [AddrW-1:0] waddr;
    entry_t      wdata;
  } mem_ctl_t;
endpackage

[rtl/wpts_if.sv]
// ----------------------------------------------------------------------------
// wpts_req_if / wpts_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface wpts_req_if import wpts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wpts_rsp_if import wpts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/wpts_heap_mem.sv]
// ----------------------------------------------------------------------------
// wpts_heap_mem
// heap entry storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module wpts_heap_mem import wpts_pkg::*; (
  input  logic     clk,
  input  mem_ctl_t ctl,
  output entry_t   rdata
);
  entry_t mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end
endmodule

[rtl/wpts_seq.sv]
// ----------------------------------------------------------------------------
// wpts_seq
// request sequencer: sift up on add, sift down on removal, penalty tracking
// ----------------------------------------------------------------------------
module wpts_seq import wpts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_fire,
  input  req_t     req,
  output logic     busy,
  output logic     rsp_load,
  output rsp_t     rsp,
  output mem_ctl_t ctl,
  input  entry_t   rdata
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_UPRD  = 9'b000000100,
    S_UPCMP = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_LAST  = 9'b000100000,
    S_DNL   = 9'b001000000,
    S_DNR   = 9'b010000000,
    S_DNCMP = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [PenW-1:0]  pen_r, pen_nxt;
  logic [AddrW-1:0] pos_r, pos_nxt;
  logic [AddrW-1:0] best_r, best_nxt;
  entry_t           cur_r, cur_nxt;
  entry_t           lch_r, lch_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [15:0]      sw_r, sw_nxt;
  logic             served_r, served_nxt;
  logic [1:0]       err_r, err_nxt;

  logic [CountW-1:0] lidx, ridx;
  logic [PenW-1:0]   sum;
  logic              ovf;

  always_comb begin
    lidx = {pos_r, 1'b1};
    ridx = lidx + 1'b1;
    {ovf, sum} = {1'b0, pen_r} + {{(PenW-32){1'b0}}, prod_r};
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pen_nxt = pen_r;
    pos_nxt = pos_r;
    best_nxt = best_r;
    cur_nxt = cur_r;
    lch_nxt = lch_r;
    prod_nxt = prod_r;
    sw_nxt = sw_r;
    served_nxt = served_r;
    err_nxt = err_r;
    rsp_load = 1'b0;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          served_nxt = 1'b0;
          sw_nxt = '0;
          err_nxt = ERR_OK;
          if (req.command == CMD_ADD) begin
            if (count_r >= CountW'(QueueDepth)) begin
              err_nxt = ERR_FULL;
              rsp_load = 1'b1;
            end else if (req.work == '0) begin
              err_nxt = ERR_ZERO;
              rsp_load = 1'b1;
            end else begin
              cur_nxt = '{weight: req.priority_req, work: req.work};
              pos_nxt = count_r[AddrW-1:0];
              count_nxt = count_r + 1'b1;
              state_nxt = S_MUL;
            end
          end else if (count_r != '0) begin
            ctl.re = 1'b1;
            ctl.raddr = '0;
            state_nxt = S_ROOT;
          end else begin
            rsp_load = 1'b1;
          end
        end
      end
      S_MUL: begin
        prod_nxt = cur_r.weight * cur_r.work;
        state_nxt = S_UPRD;
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = cur_r;
          pen_nxt = ovf ? PenMax : sum;
          rsp_load = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctl.re = 1'b1;
          ctl.raddr = AddrW'((pos_r - 1'b1) >> 1);
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        // parent moves down while strictly smaller than the new job
        if (rdata.weight < cur_r.weight) begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = rdata;
          pos_nxt = AddrW'((pos_r - 1'b1) >> 1);
          state_nxt = S_UPRD;
        end else begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = cur_r;
          pen_nxt = ovf ? PenMax : sum;
          rsp_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ROOT: begin
        served_nxt = 1'b1;
        sw_nxt = rdata.weight;
        pen_nxt = (pen_r >= PenW'(rdata.weight)) ? pen_r - PenW'(rdata.weight) : '0;
        if (rdata.work > 16'd1) begin
          ctl.we = 1'b1;
          ctl.waddr = '0;
          ctl.wdata = '{weight: rdata.weight, work: rdata.work - 16'd1};
          rsp_load = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          count_nxt = count_r - 1'b1;
          if (count_r == CountW'(1)) begin
            rsp_load = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ctl.re = 1'b1;
            ctl.raddr = AddrW'(count_r - 1'b1);
            pos_nxt = '0;
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        cur_nxt = rdata;
        state_nxt = S_DNL;
      end
      S_DNL: begin
        if (lidx >= count_r) begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = cur_r;
          rsp_load = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctl.re = 1'b1;
          ctl.raddr = lidx[AddrW-1:0];
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        lch_nxt = rdata;
        best_nxt = lidx[AddrW-1:0];
        if (ridx < count_r) begin
          ctl.re = 1'b1;
          ctl.raddr = ridx[AddrW-1:0];
          state_nxt = S_DNCMP;
        end else if (rdata.weight > cur_r.weight) begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = rdata;
          pos_nxt = lidx[AddrW-1:0];
          state_nxt = S_DNL;
        end else begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = cur_r;
          rsp_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DNCMP: begin
        if (rdata.weight > lch_r.weight) begin
          if (rdata.weight > cur_r.weight) begin
            ctl.we = 1'b1;
            ctl.waddr = pos_r;
            ctl.wdata = rdata;
            pos_nxt = ridx[AddrW-1:0];
            state_nxt = S_DNL;
          end else begin
            ctl.we = 1'b1;
            ctl.waddr = pos_r;
            ctl.wdata = cur_r;
            rsp_load = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (lch_r.weight > cur_r.weight) begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = lch_r;
          pos_nxt = best_r;
          state_nxt = S_DNL;
        end else begin
          ctl.we = 1'b1;
          ctl.waddr = pos_r;
          ctl.wdata = cur_r;
          rsp_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != S_IDLE);
    rsp.served = served_nxt;
    rsp.served_priority = sw_nxt;
    rsp.penalty = pen_nxt;
    rsp.error = err_nxt;
    rsp.occupancy = 11'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pen_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pen_r <= pen_nxt;
    end
    pos_r <= pos_nxt;
    best_r <= best_nxt;
    cur_r <= cur_nxt;
    lch_r <= lch_nxt;
    prod_r <= prod_nxt;
    sw_r <= sw_nxt;
    served_r <= served_nxt;
    err_r <= err_nxt;
  end
endmodule

[rtl/weighted_priority_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// weighted_priority_tick_scheduler
// max-heap job scheduler with add and tick requests and a penalty total
// ----------------------------------------------------------------------------
// refused adds and empty ticks are answered from idle, a tick that keeps the
// root reads and rewrites it, an add multiplies, then reads and compares
// one parent per level moved up, a removal reads the root and the last entry
// and then reads the children of each level it moves down
// throughput: one request at a time, next one enters once the result is taken
// reset: heap count and penalty cleared, heap memory left uninitialized
module weighted_priority_tick_scheduler import wpts_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  wpts_req_if.sink  in_req,
  wpts_rsp_if.source out_rsp
);
  logic     busy, rsp_load, out_valid_r, req_fire;
  rsp_t     rsp, out_data_r;
  mem_ctl_t ctl;
  entry_t   rdata;

  assign in_req.ready = !busy && (!out_valid_r || out_rsp.ready);
  assign req_fire = in_req.valid && in_req.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data = out_data_r;

  wpts_seq u_seq (
    .clk(clk), .rst_n(rst_n), .req_fire(req_fire), .req(in_req.data),
    .busy(busy), .rsp_load(rsp_load), .rsp(rsp), .ctl(ctl), .rdata(rdata)
  );

  wpts_heap_mem u_mem (.clk(clk), .ctl(ctl), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
    if (rsp_load) begin
      out_data_r <= rsp;
    end
  end
endmodule

[rtl/wpts_checker.sv]
// ----------------------------------------------------------------------------
// wpts_checker
// port-level checks on the tick scheduler
// ----------------------------------------------------------------------------
`include "weighted_priority_tick_scheduler_assert.svh"
module wpts_checker import wpts_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  `WPTS_ASSERT_IMP(a_err_no_serve, clk, rst_n, out_valid && out_data.error != ERR_OK, !out_data.served, "error with served")
  `WPTS_ASSERT_IMP(a_serve_zero, clk, rst_n, out_valid && !out_data.served, out_data.served_priority == '0, "priority without serve")
  `WPTS_ASSERT_IMP(a_err_code, clk, rst_n, out_valid, out_data.error != 2'd3, "bad error code")
  `WPTS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `WPTS_ASSERT_IMP(a_one_inflight, clk, rst_n, in_valid && in_ready, !out_valid || out_ready, "request over waiting result")
endmodule

bind weighted_priority_tick_scheduler wpts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_data(out_rsp.data)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives add and tick requests into the heap scheduler, predicts every result
// with a behavioral heap and compares each field in order of arrival
// ----------------------------------------------------------------------------
module testbench;
  import wpts_pkg::*;

  logic clk;
  logic rst_n;

  wpts_req_if in_req ();
  wpts_rsp_if out_rsp ();

  weighted_priority_tick_scheduler DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req.sink),
    .out_rsp(out_rsp.source)
  );

  // behavioral heap
  logic [15:0] heap_weight [QueueDepth];
  logic [15:0] heap_work [QueueDepth];
  int unsigned job_count;
  logic [47:0] penalty_sum;

  rsp_t pending_rsp [$];
  int err_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    err_count++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  function automatic void swap_jobs(input int unsigned a, input int unsigned b);
    logic [15:0] tw;
    logic [15:0] tu;
    tw = heap_weight[a];
    tu = heap_work[a];
    heap_weight[a] = heap_weight[b];
    heap_work[a] = heap_work[b];
    heap_weight[b] = tw;
    heap_work[b] = tu;
  endfunction

  function automatic rsp_t schedule_step(input req_t rq);
    rsp_t rs;
    int unsigned pos;
    int unsigned parent;
    int unsigned lc;
    int unsigned best;
    logic [47:0] product;
    rs = '0;
    rs.error = ERR_OK;
    if (rq.command == CMD_ADD) begin
      if (job_count >= QueueDepth) begin
        rs.error = ERR_FULL;
      end else if (rq.work == 16'd0) begin
        rs.error = ERR_ZERO;
      end else begin
        product = 48'(rq.priority_req) * 48'(rq.work);
        pos = job_count;
        heap_weight[pos] = rq.priority_req;
        heap_work[pos] = rq.work;
        job_count++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_weight[parent] < heap_weight[pos]) begin
            swap_jobs(parent, pos);
            pos = parent;
          end else begin
            break;
          end
        end
        if (penalty_sum > PenMax - product) penalty_sum = PenMax;
        else penalty_sum = penalty_sum + product;
      end
    end else if (job_count > 0) begin
      rs.served = 1'b1;
      rs.served_priority = heap_weight[0];
      if (penalty_sum >= 48'(heap_weight[0])) penalty_sum = penalty_sum - heap_weight[0];
      else penalty_sum = '0;
      if (heap_work[0] > 16'd1) begin
        heap_work[0] = heap_work[0] - 16'd1;
      end else begin
        job_count--;
        if (job_count > 0) begin
          heap_weight[0] = heap_weight[job_count];
          heap_work[0] = heap_work[job_count];
          pos = 0;
          forever begin
            lc = 2 * pos + 1;
            if (lc >= job_count) break;
            best = lc;
            if (lc + 1 < job_count && heap_weight[lc + 1] > heap_weight[lc]) best = lc + 1;
            if (heap_weight[best] > heap_weight[pos]) begin
              swap_jobs(best, pos);
              pos = best;
            end else begin
              break;
            end
          end
        end
      end
    end
    rs.penalty = penalty_sum;
    rs.occupancy = 11'(job_count);
    return rs;
  endfunction

  task automatic send_request(input logic cmd, input logic [15:0] w,
                              input logic [15:0] u);
    req_t rq;
    rsp_t pred;
    rq.command = cmd;
    rq.priority_req = w;
    rq.work = u;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_req.valid = 1'b1;
    in_req.data = rq;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pred = schedule_step(rq);
    pending_rsp = {pending_rsp, pred};
    @(negedge clk);
    in_req.valid = 1'b0;
  endtask

  // receiver ready pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.data.served !== want.served)
          report_mismatch("served", out_rsp.data.served, want.served);
        if (out_rsp.data.served_priority !== want.served_priority)
          report_mismatch("served_priority", out_rsp.data.served_priority,
                          want.served_priority);
        if (out_rsp.data.penalty !== want.penalty)
          report_mismatch("penalty", out_rsp.data.penalty, want.penalty);
        if (out_rsp.data.error !== want.error)
          report_mismatch("error", out_rsp.data.error, want.error);
        if (out_rsp.data.occupancy !== want.occupancy)
          report_mismatch("occupancy", out_rsp.data.occupancy, want.occupancy);
      end
    end
  end

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(CMD_TICK, 16'h1234, 16'h5678);  // tick on empty queue
    send_request(CMD_ADD, 16'hffff, 16'd0);      // zero work
    send_request(CMD_ADD, 16'd0, 16'd3);         // zero weight accepted
    send_request(CMD_ADD, 16'hffff, 16'hffff);
    send_request(CMD_ADD, 16'd5, 16'd1);
    send_request(CMD_ADD, 16'd5, 16'd2);         // equal weights
    send_request(CMD_ADD, 16'd5, 16'd1);
    send_request(CMD_ADD, 16'h8000, 16'h0001);
    send_request(CMD_ADD, 16'h7fff, 16'hfffe);
    repeat (6) send_request(CMD_TICK, 16'hffff, 16'hffff);
    send_request(CMD_ADD, 16'hffff, 16'h0001);
    repeat (6) send_request(CMD_TICK, 16'd0, 16'd0);
    drain_results();
  endtask

  task automatic test_random_mix(input int n);
    logic cmd;
    logic [15:0] w;
    logic [15:0] u;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(99) < 45) ? CMD_TICK : CMD_ADD;
      w = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
      case ($urandom_range(9))
        0: u = 16'd0;
        1: u = 16'($urandom);
        default: u = 16'($urandom_range(1, 3));
      endcase
      send_request(cmd, w, u);
    end
  endtask

  // fill the heap to capacity and overflow it, then serve from the deep heap
  task automatic test_full_queue();
    while (job_count < QueueDepth) send_request(CMD_ADD, 16'($urandom), 16'($urandom_range(1, 2)));
    send_request(CMD_ADD, 16'hffff, 16'd0);  // full wins over zero work
    send_request(CMD_ADD, 16'h0001, 16'd1);
    drain_results();
    repeat (24) send_request(CMD_TICK, 16'($urandom), 16'($urandom));
    drain_results();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 400;
    test_random_mix(40);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.data = '0;
    out_rsp.ready = 1'b0;
    job_count = 0;
    penalty_sum = '0;
    err_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    send_idle_pct = 30;
    recv_idle_pct = 87;
    test_random_mix(250);
    test_backpressure();
    send_idle_pct = 87;
    recv_idle_pct = 30;
    test_random_mix(250);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(250);
    test_full_queue();

    drain_results();
    repeat (100) @(negedge clk);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
